>>> hdl/betw_pkg.sv
// shared types and constants of the bounce ease position tween
`timescale 1ns / 1ps
package betw_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_DUR   = 3'd1;
    localparam logic [2:0] REG_SX    = 3'd2;
    localparam logic [2:0] REG_SY    = 3'd3;
    localparam logic [2:0] REG_SZ    = 3'd4;
    localparam logic [2:0] REG_EX    = 3'd5;
    localparam logic [2:0] REG_EY    = 3'd6;
    localparam logic [2:0] REG_EZ    = 3'd7;

    // ease modes
    localparam logic [1:0] MODE_IN    = 2'd0;
    localparam logic [1:0] MODE_OUT   = 2'd1;
    localparam logic [1:0] MODE_INOUT = 2'd2;
    localparam logic [1:0] MODE_ZERO  = 2'd3;

    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam int          QDEPTH      = 2;

    // curve piece offsets and bases, Q16
    localparam logic [16:0] OFF1  = 17'd35747;
    localparam logic [16:0] OFF2  = 17'd53620;
    localparam logic [16:0] OFF3  = 17'd62557;
    localparam logic [16:0] BASE1 = 17'd49152;
    localparam logic [16:0] BASE2 = 17'd61440;
    localparam logic [16:0] BASE3 = 17'd64512;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // job handed from the front to the back part
    typedef struct packed {
        logic        fin;      // finishing tick: emit end position
        logic        zero;     // mode three: emit zeros
        logic [1:0]  form;     // how e2 is built from the curve
        logic [16:0] u;        // curve argument, 0..d
        logic [15:0] d;        // effective duration
    } t_job;

endpackage

>>> hdl/betw_front.sv
// front part: keeps elapsed time and running flag, classifies each beat
`timescale 1ns / 1ps
module betw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_restart,
    input  logic [15:0]   i_delta,
    input  logic [1:0]    i_mode,
    input  logic [15:0]   i_dur,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output betw_pkg::t_job o_job
);
    import betw_pkg::*;

    logic        r_running;
    logic [16:0] r_elapsed;
    logic [17:0] sum;
    logic [16:0] n_elapsed;
    logic [15:0] d;
    logic [17:0] t2;
    t_job        job;
    logic        emit;

    assign o_ready = i_job_ready;

    // saturating elapsed update and job classification
    always_comb begin
        sum       = {1'b0, r_elapsed} + {2'b0, i_delta};
        n_elapsed = (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[16:0];
        d         = (i_dur == 16'd0) ? 16'd1 : i_dur;
        t2        = {n_elapsed, 1'b0};
        job.fin   = n_elapsed > {1'b0, d};
        job.zero  = (i_mode == MODE_ZERO);
        job.form  = i_mode;
        job.d     = d;
        job.u     = 17'd0;
        unique case (i_mode)
            MODE_IN:  job.u = {1'b0, d} - n_elapsed;
            MODE_OUT: job.u = n_elapsed;
            default: begin
                if (t2 < {2'b0, d}) begin
                    job.u = 17'({2'b0, d} - t2);
                end else begin
                    job.u    = 17'(t2 - {2'b0, d});
                    job.form = MODE_ZERO;
                end
            end
        endcase
        if (i_mode == MODE_ZERO) job.form = MODE_OUT;
        emit = r_running && !i_restart;
    end

    assign o_job_valid = i_valid && emit;
    assign o_job       = job;

    // elapsed time and running flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_elapsed <= 17'd0;
        end else if (i_valid && o_ready) begin
            if (i_restart) begin
                r_running <= 1'b1;
                r_elapsed <= 17'd0;
            end else if (r_running) begin
                r_elapsed <= n_elapsed;
                if (job.fin) r_running <= 1'b0;
            end
        end
    end

endmodule

>>> hdl/betw_queue.sv
// short job queue between the front and back parts
`timescale 1ns / 1ps
module betw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wvalid,
    output logic           o_wready,
    input  betw_pkg::t_job i_wdata,
    output logic           o_rvalid,
    input  logic           i_rready,
    output betw_pkg::t_job o_rdata
);
    import betw_pkg::*;

    t_job       r_mem [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_wready = (r_cnt != 2'(QDEPTH));
    assign o_rvalid = (r_cnt != 2'd0);
    assign o_rdata  = r_mem[r_rp];
    assign wr = i_wvalid && o_wready;
    assign rd = o_rvalid && i_rready;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wdata;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

endmodule

>>> hdl/betw_back.sv
// back part: phase divider, bounce curve and position blend
`timescale 1ns / 1ps
module betw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  betw_pkg::t_job i_job,
    input  logic [31:0]    i_sx,
    input  logic [31:0]    i_sy,
    input  logic [31:0]    i_sz,
    input  logic [31:0]    i_ex,
    input  logic [31:0]    i_ey,
    input  logic [31:0]    i_ez,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_x,
    output logic [31:0]    o_y,
    output logic [31:0]    o_z,
    output logic           o_fin
);
    import betw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_CURVE, S_SQ, S_E2, S_MUL, S_OUT
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic [32:0]        r_num;   // shifting dividend, quotient collects below
    logic [16:0]        r_rem;
    logic [4:0]         r_cnt;
    logic [16:0]        r_p;
    logic signed [17:0] r_s;
    logic [16:0]        r_k;
    logic [35:0]        r_sq;
    logic [17:0]        r_e2;
    logic [1:0]         r_ax;
    logic signed [32:0] r_diff;
    logic signed [51:0] r_prod;
    logic [31:0]        r_x, r_y, r_z;
    logic               r_fin;
    logic               r_valid;

    logic [17:0]        rem_sh;
    logic [17:0]        rem_sub;
    logic [20:0]        p11;
    logic [42:0]        v121;
    logic [17:0]        fsum;
    logic [16:0]        f;
    logic [31:0]        a_s;
    logic [31:0]        a_e;
    logic signed [51:0] rounded;
    logic [31:0]        placed;

    // divider step, curve piece, curve value and blend result
    always_comb begin
        rem_sh  = {r_rem, r_num[32]};
        rem_sub = rem_sh - {2'b0, r_job.d};
        p11     = 21'(r_p) * 21'd11;
        v121    = (43'(r_sq) * 43'd121 + 43'h80000) >> 20;
        fsum    = {1'b0, r_k} + 18'(v121);
        f       = (fsum > {1'b0, ONE_Q16}) ? ONE_Q16 : fsum[16:0];
        unique case (r_ax)
            2'd0:    begin a_s = i_sx; a_e = i_ex; end
            2'd1:    begin a_s = i_sy; a_e = i_ey; end
            default: begin a_s = i_sz; a_e = i_ez; end
        endcase
        rounded = (r_prod + 52'sd65536) >>> 17;
        placed  = a_s + rounded[31:0];
    end

    assign o_job_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_fin = r_fin;

    // sequencer: 17-step restoring divide, curve, then three blends; finishing and zero jobs go straight to output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_valid && i_ready) r_valid <= 1'b0;
                    if (i_job_valid && o_job_ready) begin
                        r_job <= i_job;
                        r_fin <= i_job.fin;
                        if (i_job.fin) begin
                            r_x <= i_ex; r_y <= i_ey; r_z <= i_ez;
                            r_state <= S_OUT;
                        end else if (i_job.zero) begin
                            r_x <= '0; r_y <= '0; r_z <= '0;
                            r_state <= S_OUT;
                        end else begin
                            // u <= d, so the top 16 quotient bits are zero:
                            // start with those dividend bits already in the remainder
                            r_num   <= {i_job.u[0], 32'd0};
                            r_rem   <= {1'b0, i_job.u[16:1]};
                            r_cnt   <= 5'd0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (!rem_sub[17]) begin
                        r_rem <= rem_sub[16:0];
                        r_num <= {r_num[31:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[16:0];
                        r_num <= {r_num[31:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) r_state <= S_CURVE;
                end
                S_CURVE: begin
                    r_p     <= r_num[16:0];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (p11 < 21'd262144) begin
                        r_s <= 18'(r_p); r_k <= 17'd0;
                    end else if (p11 < 21'd524288) begin
                        r_s <= 18'(r_p) - 18'(OFF1); r_k <= BASE1;
                    end else if (p11 < 21'd655360) begin
                        r_s <= 18'(r_p) - 18'(OFF2); r_k <= BASE2;
                    end else begin
                        r_s <= 18'(r_p) - 18'(OFF3); r_k <= BASE3;
                    end
                    r_state <= S_E2;
                    r_cnt   <= 5'd0;
                end
                S_E2: begin
                    if (r_cnt == 5'd0) begin
                        r_sq  <= 36'(r_s * r_s);
                        r_cnt <= 5'd1;
                    end else begin
                        unique case (r_job.form)
                            MODE_IN:    r_e2 <= {ONE_Q16 - f, 1'b0};
                            MODE_OUT:   r_e2 <= {f, 1'b0};
                            MODE_INOUT: r_e2 <= 18'(ONE_Q16 - f);
                            default:    r_e2 <= 18'(ONE_Q16) + 18'(f);
                        endcase
                        r_ax    <= 2'd0;
                        r_cnt   <= 5'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (r_cnt[1:0])
                        2'd0: begin
                            r_diff <= $signed({a_e[31], a_e}) - $signed({a_s[31], a_s});
                            r_cnt  <= 5'd1;
                        end
                        2'd1: begin
                            r_prod <= 52'(r_diff) * $signed({34'd0, r_e2});
                            r_cnt  <= 5'd2;
                        end
                        default: begin
                            unique case (r_ax)
                                2'd0:    r_x <= placed;
                                2'd1:    r_y <= placed;
                                default: r_z <= placed;
                            endcase
                            r_cnt <= 5'd0;
                            if (r_ax == 2'd2) r_state <= S_OUT;
                            else r_ax <= r_ax + 2'd1;
                        end
                    endcase
                end
                default: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/bounce_ease_position_tween.sv
// top level of the bounce ease position tween
`timescale 1ns / 1ps
// Bounce-eased 3-D position tween. Configuration registers (index 0..7:
// ease_mode, duration, start x/y/z, end x/y/z) must be written by the user
// on the cfg channel while idle; the block does not enforce this. A restart
// beat starts the motion and gives no result; each tick beat advances time
// and, while running, gives one position beat. The back part uses a 17-step
// restoring phase divider, the bounce curve and one shared 33x18 multiplier
// used three times; finishing and mode-three ticks skip these. A two-entry
// job queue lets the front take new beats while the back is busy.
module bounce_ease_position_tween (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // delta_ticks
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // pos_x, pos_y, pos_z
    output logic        m_axis_tlast,   // finished
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import betw_pkg::*;

    logic [1:0]  r_mode;
    logic [15:0] r_dur;
    logic [31:0] r_sx, r_sy, r_sz, r_ex, r_ey, r_ez;
    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    t_job        fj, bj;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_OUT; r_dur <= 16'd1;
            r_sx <= '0; r_sy <= '0; r_sz <= '0;
            r_ex <= '0; r_ey <= '0; r_ez <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE: r_mode <= i_cfg_data[1:0];
                REG_DUR:  r_dur  <= i_cfg_data[15:0];
                REG_SX:   r_sx   <= i_cfg_data;
                REG_SY:   r_sy   <= i_cfg_data;
                REG_SZ:   r_sz   <= i_cfg_data;
                REG_EX:   r_ex   <= i_cfg_data;
                REG_EY:   r_ey   <= i_cfg_data;
                default:  r_ez   <= i_cfg_data;
            endcase
        end
    end

    betw_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_restart(s_axis_tuser), .i_delta(s_axis_tdata),
        .i_mode(r_mode), .i_dur(r_dur),
        .o_job_valid(fj_valid), .i_job_ready(fj_ready), .o_job(fj)
    );

    betw_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wvalid(fj_valid), .o_wready(fj_ready), .i_wdata(fj),
        .o_rvalid(bj_valid), .i_rready(bj_ready), .o_rdata(bj)
    );

    betw_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(bj_valid), .o_job_ready(bj_ready), .i_job(bj),
        .i_sx(r_sx), .i_sy(r_sy), .i_sz(r_sz),
        .i_ex(r_ex), .i_ey(r_ey), .i_ez(r_ez),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_x(m_axis_tdata[31:0]), .o_y(m_axis_tdata[63:32]),
        .o_z(m_axis_tdata[95:64]), .o_fin(m_axis_tlast)
    );

endmodule

>>> verif/betw_scoreboard.sv
// checker for the bounce ease position tween: predicts and compares position beats
`timescale 1ns / 1ps
module betw_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_failures,
    output int          o_pending,
    output int          o_results
);
    import betw_pkg::*;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        fin;
    } t_pos;

    t_pos        pos_queue[$];
    logic [1:0]  mode;
    logic [15:0] dur;
    logic [31:0] org[3];
    logic [31:0] dst[3];
    logic [16:0] elapsed;
    logic        running;

    // bounce ease-out curve, Q16 phase in, Q16 value out
    function automatic longint bounce_curve(input longint p);
        longint s;
        longint k;
        longint v;
        if (p * 11 < 262144) begin
            s = p; k = 0;
        end else if (p * 11 < 524288) begin
            s = p - longint'(OFF1); k = longint'(BASE1);
        end else if (p * 11 < 655360) begin
            s = p - longint'(OFF2); k = longint'(BASE2);
        end else begin
            s = p - longint'(OFF3); k = longint'(BASE3);
        end
        v = (s * s * 121 + 524288) >>> 20;
        k = k + v;
        if (k > 65536) k = 65536;
        return k;
    endfunction

    function automatic longint phase_q16(input longint u, input longint d);
        return (u << 16) / d;
    endfunction

    // start plus rounded share of the span, doubled fraction in Q17
    function automatic logic [31:0] blend_axis(input logic [31:0] a0, input logic [31:0] b0,
                                               input longint e2);
        longint a;
        longint c;
        longint r;
        a = longint'(signed'(a0));
        c = longint'(signed'(b0)) - a;
        r = (c * e2 + 65536) >>> 17;
        return 32'(a + r);
    endfunction

    // predict what one accepted input beat produces
    task automatic predict_beat(input logic rst_item, input logic [15:0] delta);
        longint sum;
        longint d;
        longint t;
        longint e2;
        t_pos   p;
        if (rst_item) begin
            elapsed = '0;
            running = 1'b1;
            return;
        end
        if (!running) return;
        sum = longint'(elapsed) + longint'(delta);
        elapsed = (sum > longint'(ELAPSED_MAX)) ? ELAPSED_MAX : 17'(sum);
        d = (dur == 16'd0) ? 1 : longint'(dur);
        t = longint'(elapsed);
        if (t > d) begin
            running = 1'b0;
            p = '{dst[0], dst[1], dst[2], 1'b1};
        end else if (mode == MODE_ZERO) begin
            p = '{32'd0, 32'd0, 32'd0, 1'b0};
        end else begin
            case (mode)
                MODE_IN:  e2 = 2 * (65536 - bounce_curve(phase_q16(d - t, d)));
                MODE_OUT: e2 = 2 * bounce_curve(phase_q16(t, d));
                default: begin
                    if (2 * t < d) e2 = 65536 - bounce_curve(phase_q16(d - 2 * t, d));
                    else e2 = 65536 + bounce_curve(phase_q16(2 * t - d, d));
                end
            endcase
            p.x = blend_axis(org[0], dst[0], e2);
            p.y = blend_axis(org[1], dst[1], e2);
            p.z = blend_axis(org[2], dst[2], e2);
            p.fin = 1'b0;
        end
        pos_queue.push_back(p);
    endtask

    always @(posedge i_clk) begin
        t_pos want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            mode = MODE_OUT;
            dur = 16'd1;
            for (int i = 0; i < 3; i++) begin
                org[i] = '0;
                dst[i] = '0;
            end
            elapsed = '0;
            running = 1'b0;
            pos_queue.delete();
            o_failures <= 0;
            o_results <= 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE: mode = i_cfg_data[1:0];
                    REG_DUR:  dur = i_cfg_data[15:0];
                    REG_SX:   org[0] = i_cfg_data;
                    REG_SY:   org[1] = i_cfg_data;
                    REG_SZ:   org[2] = i_cfg_data;
                    REG_EX:   dst[0] = i_cfg_data;
                    REG_EY:   dst[1] = i_cfg_data;
                    REG_EZ:   dst[2] = i_cfg_data;
                    default: ;
                endcase
            end
            // input beats
            if (i_s_tvalid && i_s_tready) predict_beat(i_s_tuser, i_s_tdata);
            // output beats
            if (i_m_tvalid && i_m_tready) begin
                o_results <= o_results + 1;
                if (pos_queue.size() == 0) begin
                    $error("position beat with none expected");
                    errs++;
                end else begin
                    want = pos_queue.pop_front();
                    if (want.x !== i_m_tdata[31:0]) begin
                        $error("pos_x expected %h got %h", want.x, i_m_tdata[31:0]);
                        errs++;
                    end
                    if (want.y !== i_m_tdata[63:32]) begin
                        $error("pos_y expected %h got %h", want.y, i_m_tdata[63:32]);
                        errs++;
                    end
                    if (want.z !== i_m_tdata[95:64]) begin
                        $error("pos_z expected %h got %h", want.z, i_m_tdata[95:64]);
                        errs++;
                    end
                    if (want.fin !== i_m_tlast) begin
                        $error("finished expected %0d got %0d", want.fin, i_m_tlast);
                        errs++;
                    end
                end
            end
            o_failures <= o_failures + errs;
        end
        o_pending <= pos_queue.size();
    end

endmodule

>>> verif/bounce_ease_position_tween_tb.sv
// testbench top of the bounce ease position tween: stimulus, clock and verdict
`timescale 1ns / 1ps
module bounce_ease_position_tween_tb;
    import betw_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          failures;
    int          pending;
    int          results;
    int          beats_sent;
    int          cycles;
    logic        calm;
    logic [15:0] cur_dur;

    bounce_ease_position_tween dut (.*);

    betw_scoreboard u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_failures(failures), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stalls about a third of the time unless calm
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_DUR) cur_dur = val[15:0];
    endtask

    // one input beat, sometimes with a random gap ahead of it unless calm
    task automatic send_beat(input logic rst_item, input logic [15:0] delta);
        if (!calm && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rst_item;
        s_axis_tdata  <= delta;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    // drop valid and let every expected position drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_all(input logic [1:0] m, input logic [15:0] d);
        write_reg(REG_MODE, 32'(m));
        write_reg(REG_DUR, 32'(d));
        for (int i = 0; i < 6; i++) write_reg(REG_SX + 3'(i), pick_coord());
    endtask

    initial begin
        logic [15:0] delta;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        beats_sent = 0;
        cycles = 0;
        calm = 1'b0;
        cur_dur = 16'd1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stopped tick, then a short run to the finish
        send_beat(1'b0, 16'd5);
        send_beat(1'b1, 16'd0);
        send_beat(1'b0, 16'd0);
        send_beat(1'b0, 16'd1);
        send_beat(1'b0, 16'd1);
        settle();

        // ease in, zero duration, extreme corners
        write_reg(REG_MODE, 32'(MODE_IN));
        write_reg(REG_DUR, 32'd0);
        write_reg(REG_SX, 32'h8000_0000);
        write_reg(REG_SY, 32'h7FFF_FFFF);
        write_reg(REG_SZ, 32'd0);
        write_reg(REG_EX, 32'h7FFF_FFFF);
        write_reg(REG_EY, 32'h8000_0000);
        write_reg(REG_EZ, 32'hFFFF_FFFF);
        send_beat(1'b1, 16'hFFFF);
        send_beat(1'b0, 16'd0);
        send_beat(1'b0, 16'hFFFF);
        send_beat(1'b0, 16'd3);
        settle();

        // ease in-out over the longest duration, then lower it mid-run
        write_reg(REG_MODE, 32'(MODE_INOUT));
        write_reg(REG_DUR, 32'd65535);
        send_beat(1'b1, 16'd0);
        send_beat(1'b0, 16'd32767);
        send_beat(1'b0, 16'd1);
        send_beat(1'b0, 16'hFFFF);
        send_beat(1'b1, 16'h5555);
        send_beat(1'b0, 16'd100);
        settle();
        write_reg(REG_DUR, 32'd50);
        send_beat(1'b0, 16'd0);
        settle();

        // mode three gives zeros, finish still gives the end point
        write_reg(REG_MODE, 32'(MODE_ZERO));
        send_beat(1'b1, 16'hAAAA);
        send_beat(1'b0, 16'd10);
        send_beat(1'b0, 16'd60);
        settle();

        // random phases, mostly short motions and well-formed runs
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            case (ph)
                0: load_all(MODE_IN, 16'd65535);
                1: load_all(MODE_OUT, 16'd1);
                default: load_all(2'($urandom_range(0, 3)), 16'($urandom_range(1, 64)));
            endcase
            send_beat(1'b1, 16'($urandom));
            for (int n = 0; n < 103; n++) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_beat(1'b1, 16'($urandom));
                end else begin
                    if ($urandom_range(0, 99) < 10) delta = 16'($urandom);
                    else delta = 16'($urandom_range(0, cur_dur / 3 + 1));
                    send_beat(1'b0, delta);
                end
            end
            settle();
        end
        calm = 1'b0;

        $display("run: %0d input beats across directed and 8 random phases, %0d positions checked",
                 beats_sent, results);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
